/* hdl/lag_pkg.sv */
// Shared types and constants for the life automaton generation engine.
// Holds the grid dimensions, the word formats and the row unit controls.
// No dependencies.
package lag_pkg;

   localparam int MAX_WIDTH  = 128;
   localparam int MAX_HEIGHT = 128;

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = $clog2(MAX_HEIGHT);
   localparam int DIM_W   = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1);
   localparam int ADDR_W  = ROW_W + 1;
   localparam int WIN_W   = MAX_WIDTH + 2;
   localparam int NB_W    = 4;
   localparam int COUNT_W = 15;
   localparam int CFG_W   = 8;
   localparam int CSR_IDX_W = 1;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [NB_W-1:0] BIRTH_COUNT = NB_W'(3);
   localparam logic [NB_W-1:0] SURVIVE_LOW = NB_W'(2);

   localparam logic [CFG_W-1:0] GRID_WIDTH_RESET  = CFG_W'(100);
   localparam logic [CFG_W-1:0] GRID_HEIGHT_RESET = CFG_W'(100);

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT = CSR_IDX_W'(1);

   localparam logic [1:0] OP_WRITE   = 2'd0;
   localparam logic [1:0] OP_READ    = 2'd1;
   localparam logic [1:0] OP_ADVANCE = 2'd2;

   typedef struct packed {
      logic [1:0] op;
      logic [6:0] cell_x;
      logic [6:0] cell_y;
      logic       cell_value;
   } lag_req_type;

   typedef struct packed {
      logic               cell_alive;
      logic [COUNT_W-1:0] live_count;
      logic               out_of_range;
   } lag_rsp_type;

   typedef struct packed {
      logic load_prev;
      logic load_cur;
      logic load_next;
      logic step;
   } lag_row_ctrl_type;

endpackage

/* hdl/lag_row_unit.sv */
// Neighborhood window and B3/S23 rule unit, shared by every cell of a sweep.
// Holds three row windows that shift one column per step; uses lag_pkg.
module lag_row_unit import lag_pkg::*; (
   input  logic                 clock,
   input  lag_row_ctrl_type     ctrl,
   input  logic [MAX_WIDTH-1:0] row_data,
   output logic                 next_alive
);

   // Bit 0 of each window is column x-1, bit 1 is column x, bit 2 is column x+1.
   logic [WIN_W-1:0] prev_ff, prev_in;
   logic [WIN_W-1:0] cur_ff, cur_in;
   logic [WIN_W-1:0] next_ff, next_in;
   logic [NB_W-1:0]  nb_count;

   always_comb begin
      prev_in = prev_ff;
      cur_in  = cur_ff;
      next_in = next_ff;
      if (ctrl.load_prev) begin
         prev_in = {1'b0, row_data, 1'b0};
      end
      if (ctrl.load_cur) begin
         cur_in = {1'b0, row_data, 1'b0};
      end
      if (ctrl.load_next) begin
         next_in = {1'b0, row_data, 1'b0};
      end
      if (ctrl.step) begin
         prev_in = prev_ff >> 1;
         cur_in  = cur_ff >> 1;
         next_in = next_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff <= prev_in;
      cur_ff  <= cur_in;
      next_ff <= next_in;
   end

   always_comb begin
      nb_count = NB_W'(prev_ff[0]) + NB_W'(prev_ff[1]) + NB_W'(prev_ff[2])
               + NB_W'(cur_ff[0]) + NB_W'(cur_ff[2])
               + NB_W'(next_ff[0]) + NB_W'(next_ff[1]) + NB_W'(next_ff[2]);
      if (cur_ff[1]) begin
         next_alive = (nb_count == SURVIVE_LOW) || (nb_count == BIRTH_COUNT);
      end else begin
         next_alive = (nb_count == BIRTH_COUNT);
      end
   end

endmodule

/* hdl/life_automaton_generation_engine.sv */
// Top level of the life automaton generation engine (B3/S23 on a bounded grid).
// An advance visits every row in turn with three row reads, a window load, one cell step
// per column and a row write. The sequencer takes one word at a time. Reset: synchronous;
// afterwards a clearing pass zeroes both planes, during which req_stall stays high.
// Registers return to 100 by 100.
module life_automaton_generation_engine import lag_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  lag_req_type          req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output lag_rsp_type          rsp_data,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data
);

   // The sequencer walks a word through the row memory. An advance visits every
   // row: it reads the rows above, at and below, then steps the shared rule unit
   // across all columns while the new row collects in a shift register.
   typedef enum logic [9:0] {
      S_CLEAR   = 10'b0000000001,
      S_IDLE    = 10'b0000000010,
      S_RMW     = 10'b0000000100,
      S_ADV_RD0 = 10'b0000001000,
      S_ADV_RD1 = 10'b0000010000,
      S_ADV_RD2 = 10'b0000100000,
      S_ADV_RD3 = 10'b0001000000,
      S_ADV_CEL = 10'b0010000000,
      S_ADV_WR  = 10'b0100000000,
      S_FINISH  = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   logic [CFG_W-1:0] grid_width_ff, grid_width_in;
   logic [CFG_W-1:0] grid_height_ff, grid_height_in;
   logic             plane_sel_ff, plane_sel_in;
   lag_req_type      req_ff, req_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic             res_alive_ff, res_alive_in;
   logic             res_oor_ff, res_oor_in;
   logic [MAX_WIDTH-1:0] next_row_ff, next_row_in;
   logic             rsp_valid_ff, rsp_valid_in;
   lag_rsp_type      rsp_data_ff, rsp_data_in;

   // Both planes live in one row memory; the top address bit picks the plane.
   logic [MAX_WIDTH-1:0] mem [2*MAX_HEIGHT];
   logic [MAX_WIDTH-1:0] rd_data_ff;
   logic [ADDR_W-1:0]    mem_rd_addr;
   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_wr_addr;
   logic [MAX_WIDTH-1:0] mem_wr_data;

   logic [DIM_W-1:0]     eff_w, eff_h;
   logic [MAX_WIDTH-1:0] col_mask;
   logic [MAX_WIDTH-1:0] row_masked;
   logic [MAX_WIDTH-1:0] rmw_row;
   logic                 req_fire;
   logic                 req_inside;
   logic                 rsp_free;
   logic                 cell_in_grid;
   logic                 cell_next;
   logic                 cell_alive_raw;
   logic                 prev_ok, cur_ok, next_ok;
   lag_row_ctrl_type     row_ctrl;

   lag_row_unit u_row_unit (
      .clock      (clock),
      .ctrl       (row_ctrl),
      .row_data   (row_masked),
      .next_alive (cell_alive_raw)
   );

   // Registers above the grid maximum act as the maximum.
   always_comb begin
      eff_w = (32'(grid_width_ff) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : DIM_W'(grid_width_ff);
      eff_h = (32'(grid_height_ff) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : DIM_W'(grid_height_ff);
      for (int i = 0; i < MAX_WIDTH; i++) begin
         col_mask[i] = (i < 32'(eff_w));
      end
   end

   // Stored cells outside the grid read as dead neighbors.
   always_comb begin
      prev_ok = (row_ff != '0) && (32'(row_ff) <= 32'(eff_h));
      cur_ok  = (32'(row_ff) < 32'(eff_h));
      next_ok = (32'(row_ff) + 1 < 32'(eff_h));
      cell_in_grid = cur_ok && (32'(col_ff) < 32'(eff_w));
      cell_next = cell_alive_raw && cell_in_grid;
   end

   always_comb begin
      row_ctrl = '0;
      row_masked = '0;
      case (state_ff)
         S_ADV_RD1: begin
            row_ctrl.load_prev = 1'b1;
            row_masked = prev_ok ? (rd_data_ff & col_mask) : '0;
         end
         S_ADV_RD2: begin
            row_ctrl.load_cur = 1'b1;
            row_masked = cur_ok ? (rd_data_ff & col_mask) : '0;
         end
         S_ADV_RD3: begin
            row_ctrl.load_next = 1'b1;
            row_masked = next_ok ? (rd_data_ff & col_mask) : '0;
         end
         S_ADV_CEL: begin
            row_ctrl.step = 1'b1;
         end
         default: begin
            row_ctrl = '0;
         end
      endcase
   end

   always_comb begin
      rmw_row = rd_data_ff;
      rmw_row[COL_W'(req_ff.cell_x)] = req_ff.cell_value;
   end

   assign req_stall  = (state_ff != S_IDLE);
   assign req_fire   = req_valid && !req_stall;
   assign req_inside = (32'(req_data.cell_x) < 32'(eff_w))
                    && (32'(req_data.cell_y) < 32'(eff_h));
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in       = state_ff;
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      plane_sel_in   = plane_sel_ff;
      req_in         = req_ff;
      row_in         = row_ff;
      col_in         = col_ff;
      clr_in         = clr_ff;
      count_in       = count_ff;
      res_alive_in   = res_alive_ff;
      res_oor_in     = res_oor_ff;
      next_row_in    = next_row_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_data_in    = rsp_data_ff;
      mem_rd_addr    = {plane_sel_ff, row_ff};
      mem_we         = 1'b0;
      mem_wr_addr    = {plane_sel_ff, row_ff};
      mem_wr_data    = '0;

      if (csr_wr_en) begin
         if (csr_index == CSR_GRID_WIDTH) begin
            grid_width_in = csr_data;
         end
         if (csr_index == CSR_GRID_HEIGHT) begin
            grid_height_in = csr_data;
         end
      end

      case (state_ff)
         S_CLEAR: begin
            mem_we      = 1'b1;
            mem_wr_addr = clr_ff;
            mem_wr_data = '0;
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(2*MAX_HEIGHT - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            mem_rd_addr = {plane_sel_ff, ROW_W'(req_data.cell_y)};
            if (req_fire) begin
               req_in       = req_data;
               res_alive_in = 1'b0;
               res_oor_in   = 1'b0;
               count_in     = '0;
               row_in       = '0;
               col_in       = '0;
               if ((req_data.op == OP_WRITE) || (req_data.op == OP_READ)) begin
                  if (req_inside) begin
                     state_in = S_RMW;
                  end else begin
                     res_oor_in = 1'b1;
                     state_in   = S_FINISH;
                  end
               end else if (req_data.op == OP_ADVANCE) begin
                  state_in = S_ADV_RD0;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_RMW: begin
            if (req_ff.op == OP_WRITE) begin
               mem_we      = 1'b1;
               mem_wr_addr = {plane_sel_ff, ROW_W'(req_ff.cell_y)};
               mem_wr_data = rmw_row;
            end else begin
               res_alive_in = rd_data_ff[COL_W'(req_ff.cell_x)];
            end
            state_in = S_FINISH;
         end
         S_ADV_RD0: begin
            mem_rd_addr = {plane_sel_ff, row_ff - 1'b1};
            state_in = S_ADV_RD1;
         end
         S_ADV_RD1: begin
            mem_rd_addr = {plane_sel_ff, row_ff};
            state_in = S_ADV_RD2;
         end
         S_ADV_RD2: begin
            mem_rd_addr = {plane_sel_ff, row_ff + 1'b1};
            state_in = S_ADV_RD3;
         end
         S_ADV_RD3: begin
            col_in   = '0;
            state_in = S_ADV_CEL;
         end
         S_ADV_CEL: begin
            // The new row fills from the top bit, so column 0 lands in bit 0 last.
            next_row_in = {cell_next, next_row_ff[MAX_WIDTH-1:1]};
            if (cell_next && (count_ff != COUNT_MAX)) begin
               count_in = count_ff + 1'b1;
            end
            col_in = col_ff + 1'b1;
            if (col_ff == COL_W'(MAX_WIDTH - 1)) begin
               state_in = S_ADV_WR;
            end
         end
         S_ADV_WR: begin
            mem_we      = 1'b1;
            mem_wr_addr = {!plane_sel_ff, row_ff};
            mem_wr_data = next_row_ff;
            row_in      = row_ff + 1'b1;
            if (row_ff == ROW_W'(MAX_HEIGHT - 1)) begin
               plane_sel_in = !plane_sel_ff;
               state_in     = S_FINISH;
            end else begin
               state_in = S_ADV_RD0;
            end
         end
         S_FINISH: begin
            // The result word waits here until the output register is free.
            if (rsp_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.cell_alive   = res_alive_ff;
               rsp_data_in.out_of_range = res_oor_ff;
               rsp_data_in.live_count   = (req_ff.op == OP_ADVANCE) ? count_ff : '0;
               state_in                 = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         grid_width_ff  <= GRID_WIDTH_RESET;
         grid_height_ff <= GRID_HEIGHT_RESET;
         plane_sel_ff   <= 1'b0;
         clr_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
         plane_sel_ff   <= plane_sel_in;
         clr_ff         <= clr_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      row_ff       <= row_in;
      col_ff       <= col_in;
      count_ff     <= count_in;
      res_alive_ff <= res_alive_in;
      res_oor_ff   <= res_oor_in;
      next_row_ff  <= next_row_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wr_addr] <= mem_wr_data;
      end
      rd_data_ff <= mem[mem_rd_addr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* hdl/lag_checker.sv */
// Port-level checks for the life automaton generation engine.
// Bound to life_automaton_generation_engine; uses lag_pkg.
module lag_checker import lag_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input lag_rsp_type          rsp_data
);

   // Words taken in but not yet delivered.
   logic [1:0] open_ff, open_in;
   logic       req_take, rsp_take;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   always_comb begin
      open_in = open_ff + 2'(req_take) - 2'(rsp_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   a_stalled_word_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed");

   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request taken during the clearing pass");

   a_no_unasked_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (open_ff != 2'd0))
      else $error("result word without a request");

   a_at_most_two_open: assert property (@(posedge clock) disable iff (reset)
      req_take |-> (open_ff != 2'd2))
      else $error("request taken with two words open");

endmodule

bind life_automaton_generation_engine lag_checker u_lag_checker (.*);
